// ===== hw/rtl/clipped_sprite_blitter_assert.svh =====
// Assertion macros used by the checker module of the sprite blitter.
`ifndef CLIPPED_SPRITE_BLITTER_ASSERT_SVH
`define CLIPPED_SPRITE_BLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sprite blitter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sprite blitter assertion failed");

`endif

// ===== hw/rtl/csb_pkg.sv =====
// Types and constants of the clipped sprite blitter.
package csb_pkg;

    localparam int PAGE_WIDTH_DEF  = 320;
    localparam int PAGE_HEIGHT_DEF = 200;

    localparam int COORD_W  = 12;
    localparam int GROUPS_W = 8;
    localparam int ROWS_W   = 8;
    localparam int COL_W    = 11;
    localparam int PIX_W    = 8;
    localparam int ADDR_W   = 16;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_GROUPS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_ROWS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLIT_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOUR   = 3'd5;

    localparam logic [MODE_W-1:0] MODE_FILL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MASKED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEYED  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OPAQUE = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] sprite_pixel;
        logic [PIX_W-1:0] mask_pixel;
    } t_pixel;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [PIX_W-1:0]  write_data;
        logic              last;
    } t_result;

endpackage

// ===== hw/rtl/clipped_sprite_blitter.sv =====
// Top level of the clipped sprite blitter.
// The blitter takes sprite pixel beats and returns one page write beat per pixel: the
// first register stage holds the pixel with its row and column, the second holds the
// clipped, mode-filtered write. The first stage also takes a new pixel whenever it is
// empty, so a new pixel is taken while a finished write still waits for the consumer.
// Sustained rate is one pixel per cycle while the consumer takes every write; the
// longest path is the multiply-add for the page address in the second stage.
module clipped_sprite_blitter
    import csb_pkg::*;
#(
    parameter int PAGE_WIDTH  = PAGE_WIDTH_DEF,
    parameter int PAGE_HEIGHT = PAGE_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_pixel                i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_result               o_out
);

    localparam int P_W = COORD_W + 2;
    localparam logic [P_W-1:0] PW_C = P_W'(PAGE_WIDTH);
    localparam logic [P_W-1:0] PH_C = P_W'(PAGE_HEIGHT);

    logic [COORD_W-1:0]  r_origin_x;
    logic [COORD_W-1:0]  r_origin_y;
    logic [GROUPS_W-1:0] r_width_groups;
    logic [ROWS_W-1:0]   r_sprite_rows;
    logic [MODE_W-1:0]   r_blit_mode;
    logic [PIX_W-1:0]    r_key_colour;

    logic [COL_W-1:0]    r_col;
    logic [ROWS_W-1:0]   r_row;
    logic [COL_W-1:0]    n_col;
    logic [ROWS_W-1:0]   n_row;

    logic                r_s1_valid;
    t_pixel              r_s1_pix;
    logic [COL_W-1:0]    r_s1_col;
    logic [ROWS_W-1:0]   r_s1_row;
    logic                r_s1_empty;
    logic                r_s1_last;

    logic                r_out_valid;
    t_result             r_out;
    t_result             n_out;

    logic                s1_ready;
    logic                s2_ready;
    logic                in_fire;
    logic [COL_W-1:0]    cols;
    logic                empty;
    logic                end_col;
    logic                end_row;

    logic [P_W-1:0]      px;
    logic [P_W-1:0]      py;
    logic [2*P_W-1:0]    prod;
    logic                in_page;
    logic                draw;

    assign o_cfg_ready = 1'b1;
    assign s2_ready    = !r_out_valid || i_out_ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign o_in_ready  = s1_ready;
    assign in_fire     = i_in_valid && s1_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_width_groups <= '0;
            r_sprite_rows  <= '0;
            r_blit_mode    <= MODE_FILL;
            r_key_colour   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ORIGIN_X:     r_origin_x     <= i_cfg_data;
                REG_ORIGIN_Y:     r_origin_y     <= i_cfg_data;
                REG_WIDTH_GROUPS: r_width_groups <= i_cfg_data[GROUPS_W-1:0];
                REG_SPRITE_ROWS:  r_sprite_rows  <= i_cfg_data[ROWS_W-1:0];
                REG_BLIT_MODE:    r_blit_mode    <= i_cfg_data[MODE_W-1:0];
                REG_KEY_COLOUR:   r_key_colour   <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    assign cols    = {r_width_groups, 3'b000};
    assign empty   = (r_width_groups == '0) || (r_sprite_rows == '0);
    assign end_col = r_col >= (cols - COL_W'(1));
    assign end_row = r_row >= (r_sprite_rows - ROWS_W'(1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (empty) begin
            n_col = '0;
            n_row = '0;
        end else if (end_col) begin
            n_col = '0;
            n_row = end_row ? '0 : r_row + ROWS_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pix   <= i_in;
            r_s1_col   <= empty ? '0 : r_col;
            r_s1_row   <= empty ? '0 : r_row;
            r_s1_empty <= empty;
            r_s1_last  <= empty || (end_col && end_row);
        end
    end

    assign px   = {{(P_W-COORD_W){r_origin_x[COORD_W-1]}}, r_origin_x}
                + P_W'(r_s1_col);
    assign py   = {{(P_W-COORD_W){r_origin_y[COORD_W-1]}}, r_origin_y}
                + P_W'(r_s1_row);
    assign prod = py * PW_C;
    assign in_page = !px[P_W-1] && (px < PW_C) && !py[P_W-1] && (py < PH_C);

    always_comb begin
        unique case (r_blit_mode)
            MODE_FILL:   draw = (r_s1_pix.sprite_pixel == '0);
            MODE_MASKED: draw = (r_s1_pix.mask_pixel == '0);
            MODE_KEYED:  draw = (r_s1_pix.sprite_pixel != r_key_colour);
            MODE_OPAQUE: draw = 1'b1;
            default:     draw = 1'b1;
        endcase
    end

    always_comb begin
        n_out.write_enable  = !r_s1_empty && in_page && draw;
        n_out.write_address = '0;
        n_out.write_data    = '0;
        n_out.last          = r_s1_last;
        if (n_out.write_enable) begin
            n_out.write_address = prod[ADDR_W-1:0] + ADDR_W'(px);
            n_out.write_data    = (r_blit_mode == MODE_FILL) ? r_key_colour
                                                             : r_s1_pix.sprite_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== hw/rtl/csb_checker.sv =====
// Port-level assertion checker of the clipped sprite blitter, with its bind.
`include "clipped_sprite_blitter_assert.svh"

module csb_checker
    import csb_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_pixel                i_in,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_result               o_out
);

    logic always_on;
    assign always_on = 1'b1;

    `CSB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))
    `CSB_ASSERT_SAME(a_idle_zero, i_clk, i_rst_n, o_out_valid && !o_out.write_enable, o_out.write_address == '0 && o_out.write_data == '0)
    `CSB_ASSERT_SAME(a_in_ready, i_clk, i_rst_n, !o_out_valid || i_out_ready, o_in_ready)
    `CSB_ASSERT_NEXT(a_reset_empty, i_clk, always_on, !i_rst_n, !o_out_valid)

endmodule

bind clipped_sprite_blitter csb_checker u_csb_checker (.*);

// ===== tb/blit_scoreboard_pkg.sv =====
// Scoreboard for the clipped sprite blitter: predicts page write beats and checks them.
package blit_scoreboard_pkg;
    import csb_pkg::*;

    class blit_scoreboard;
        logic signed [COORD_W-1:0] org_x;
        logic signed [COORD_W-1:0] org_y;
        logic [GROUPS_W-1:0]       groups;
        logic [ROWS_W-1:0]         rows;
        logic [MODE_W-1:0]         mode;
        logic [PIX_W-1:0]          key;
        logic [COL_W-1:0]          col;
        logic [ROWS_W-1:0]         row;
        t_result                   pending_writes[$];
        int unsigned               mismatches;
        int unsigned               pixels_seen;
        int unsigned               writes_checked;
        int unsigned               page_writes;
        int unsigned               sprite_ends;

        function new();
            org_x = '0;
            org_y = '0;
            groups = '0;
            rows = '0;
            mode = MODE_FILL;
            key = '0;
            col = '0;
            row = '0;
            mismatches = 0;
            pixels_seen = 0;
            writes_checked = 0;
            page_writes = 0;
            sprite_ends = 0;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ORIGIN_X:     org_x = data[COORD_W-1:0];
                REG_ORIGIN_Y:     org_y = data[COORD_W-1:0];
                REG_WIDTH_GROUPS: groups = data[GROUPS_W-1:0];
                REG_SPRITE_ROWS:  rows = data[ROWS_W-1:0];
                REG_BLIT_MODE:    mode = data[MODE_W-1:0];
                REG_KEY_COLOUR:   key = data[PIX_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(t_pixel px);
            int      cols;
            int      page_x;
            int      page_y;
            int      lin;
            bit      on_page;
            bit      draw;
            bit      end_col;
            bit      end_row;
            t_result w;
            w = '0;
            cols = int'(groups) * 8;
            if (cols == 0 || rows == '0) begin
                col = '0;
                row = '0;
                w.last = 1'b1;
            end else begin
                page_x = int'(org_x) + int'(col);
                page_y = int'(org_y) + int'(row);
                on_page = page_x >= 0 && page_x < PAGE_WIDTH_DEF
                       && page_y >= 0 && page_y < PAGE_HEIGHT_DEF;
                case (mode)
                    MODE_FILL:   draw = (px.sprite_pixel == '0);
                    MODE_MASKED: draw = (px.mask_pixel == '0);
                    MODE_KEYED:  draw = (px.sprite_pixel != key);
                    default:     draw = 1'b1;
                endcase
                if (on_page && draw) begin
                    lin = page_y * PAGE_WIDTH_DEF + page_x;
                    w.write_enable = 1'b1;
                    w.write_address = ADDR_W'(lin);
                    w.write_data = (mode == MODE_FILL) ? key : px.sprite_pixel;
                end
                end_col = int'(col) >= cols - 1;
                end_row = int'(row) >= int'(rows) - 1;
                w.last = end_col && end_row;
                if (end_col) begin
                    col = '0;
                    row = end_row ? '0 : row + 1'b1;
                end else begin
                    col = col + 1'b1;
                end
            end
            pixels_seen++;
            pending_writes.push_back(w);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH: %s", msg);
            end
        endfunction

        function void check_write(t_result got);
            t_result want;
            if (pending_writes.size() == 0) begin
                flag($sformatf("write beat with nothing expected: we=%0b addr=%0d data=%02h last=%0b",
                               got.write_enable, got.write_address, got.write_data, got.last));
                return;
            end
            want = pending_writes.pop_front();
            writes_checked++;
            if (want.write_enable) begin
                page_writes++;
            end
            if (want.last) begin
                sprite_ends++;
            end
            if (got.write_enable !== want.write_enable || got.write_address !== want.write_address
                    || got.write_data !== want.write_data || got.last !== want.last) begin
                flag($sformatf({"write beat %0d: expected we=%0b addr=%0d data=%02h last=%0b,",
                                " got we=%0b addr=%0d data=%02h last=%0b"},
                               writes_checked, want.write_enable, want.write_address,
                               want.write_data, want.last, got.write_enable,
                               got.write_address, got.write_data, got.last));
            end
        endfunction
    endclass

endpackage

// ===== tb/clipped_sprite_blitter_test.sv =====
// Testbench top for the clipped sprite blitter: drives pixel and register beats, checks writes.
module clipped_sprite_blitter_test;
    timeunit 1ns;
    timeprecision 1ps;
    import csb_pkg::*;
    import blit_scoreboard_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int RANDOM_PIXELS  = 800;
    localparam int STALL_PERCENT  = 6;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [MODE_W-1:0] MODE_ORDER [4] = '{MODE_FILL, MODE_MASKED, MODE_KEYED,
                                                     MODE_OPAQUE};
    localparam logic [15:0] DIRECTED_BEATS [16] = '{
        16'h00FF, 16'hFF00, 16'h0000, 16'h01FF,
        16'h1200, 16'h34FF, 16'hFF00, 16'h0001,
        16'hFFFF, 16'h0000, 16'hA500, 16'h5AFF,
        16'h00FF, 16'hA500, 16'hFFFF, 16'h807F
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_pixel                in_beat = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_result               out_beat;
    bit                    calm = 1'b0;
    int unsigned           settings_used = 0;
    int unsigned           idle_cycles = 0;
    blit_scoreboard        board = new();

    clipped_sprite_blitter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            board.check_write(out_beat);
        end
        out_ready <= calm || ($urandom_range(99) >= STALL_PERCENT);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_pixel(input t_pixel px);
        while (!calm && $urandom_range(99) < STALL_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_pixel(px);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.note_config(idx, val);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending_writes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        write_reg(idx, val);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic set_sprite(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                              input logic [GROUPS_W-1:0] grp, input logic [ROWS_W-1:0] rws,
                              input logic [MODE_W-1:0] md, input logic [PIX_W-1:0] kc);
        wait_drained();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_WIDTH_GROUPS, {4'($urandom), grp});
        write_reg(REG_SPRITE_ROWS, {4'($urandom), rws});
        write_reg(REG_BLIT_MODE, {10'($urandom), md});
        write_reg(REG_KEY_COLOUR, {4'($urandom), kc});
        if ($urandom_range(4) == 0) begin
            write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [COORD_W-1:0]  ox;
        logic [COORD_W-1:0]  oy;
        logic [GROUPS_W-1:0] grp;
        logic [ROWS_W-1:0]   rws;
        logic [MODE_W-1:0]   md;
        logic [PIX_W-1:0]    kc;
        t_pixel              px;
        int                  phase;
        int                  random_sent;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // With the reset registers the sprite is empty.
        send_pixel({8'h00, 8'h00});

        // A two-row sprite hanging off the left edge and lying on the bottom rows, one mode per quarter.
        set_sprite(COORD_W'(-2), COORD_W'(198), 8'd1, 8'd2, MODE_FILL, 8'hA5);
        for (int i = 0; i < 16; i++) begin
            if (i % 4 == 0 && i != 0) begin
                write_one(REG_BLIT_MODE, CFG_DATA_W'(MODE_ORDER[i / 4]));
            end
            send_pixel(DIRECTED_BEATS[i]);
        end

        // Shrinking the width while the column counter is beyond the new last column.
        set_sprite(COORD_W'(100), COORD_W'(50), 8'd2, 8'd1, MODE_OPAQUE, 8'h3C);
        repeat (9) send_pixel(16'($urandom));
        write_one(REG_WIDTH_GROUPS, CFG_DATA_W'(1));
        send_pixel(16'($urandom));

        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            case ($urandom_range(9))
                0:       ox = COORD_W'(-2048);
                1:       ox = COORD_W'(2047);
                2:       ox = COORD_W'($urandom);
                default: ox = COORD_W'($urandom_range(360) - 24);
            endcase
            case ($urandom_range(9))
                0:       oy = COORD_W'(-2048);
                1:       oy = COORD_W'(2047);
                2:       oy = COORD_W'($urandom);
                default: oy = COORD_W'($urandom_range(240) - 20);
            endcase
            case ($urandom_range(15))
                0:       grp = '0;
                1:       grp = 8'd255;
                2:       grp = GROUPS_W'($urandom_range(40, 5));
                default: grp = GROUPS_W'($urandom_range(3, 1));
            endcase
            case ($urandom_range(15))
                0:       rws = '0;
                1:       rws = 8'd255;
                default: rws = ROWS_W'($urandom_range(8, 1));
            endcase
            md = MODE_W'($urandom);
            kc = PIX_W'($urandom);
            if (phase == 0) begin
                grp = 8'd255;
                rws = 8'd255;
            end else if (phase == 1) begin
                ox = COORD_W'(-2048);
                oy = COORD_W'(2047);
            end else if (phase == 2) begin
                ox = COORD_W'(2047);
                oy = COORD_W'(-2048);
                grp = '0;
            end else if (phase == 3) begin
                rws = '0;
            end
            set_sprite(ox, oy, grp, rws, md, kc);
            calm = (phase >= 4 && phase < 9);
            repeat ($urandom_range(60, 10)) begin
                case ($urandom_range(3))
                    0:       px.sprite_pixel = 8'h00;
                    1:       px.sprite_pixel = kc;
                    2:       px.sprite_pixel = 8'hFF;
                    default: px.sprite_pixel = PIX_W'($urandom);
                endcase
                px.mask_pixel = $urandom_range(1) ? 8'h00 : PIX_W'($urandom);
                send_pixel(px);
                random_sent++;
            end
            phase++;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Checked %0d write beats from %0d pixel beats over %0d register settings.",
                 board.writes_checked, board.pixels_seen, settings_used);
        $display("%0d beats wrote the page and %0d closed a sprite; %0d mismatches.",
                 board.page_writes, board.sprite_ends, board.mismatches);
        if (board.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== clipped_sprite_blitter.f =====
+incdir+hw/rtl
hw/rtl/csb_pkg.sv
hw/rtl/clipped_sprite_blitter.sv
hw/rtl/csb_checker.sv
tb/blit_scoreboard_pkg.sv
tb/clipped_sprite_blitter_test.sv
